### rtl/core/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants for the life generation stencil
// Register codes, reset values, window bit masks and the B3/S23 rule.
// ----------------------------------------------------------------------------
package lgs_pkg;

   // configuration register codes and widths
   localparam int unsigned CSR_DATA_W = 12;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

   localparam logic [CSR_DATA_W-1:0] GRID_WIDTH_RESET  = 12'd1920;
   localparam logic [CSR_DATA_W-1:0] GRID_HEIGHT_RESET = 12'd1080;

   // 3x3 window: bits 0-2 left column, 3-5 middle, 6-8 right;
   // within a column top, middle, bottom
   localparam int unsigned WIN_W = 9;

   localparam logic [WIN_W-1:0] NEIGH_MASK  = 9'h1EF;
   localparam logic [WIN_W-1:0] TOP_MASK    = 9'h049;
   localparam logic [WIN_W-1:0] BOTTOM_MASK = 9'h124;
   localparam logic [WIN_W-1:0] LEFT_MASK   = 9'h007;
   localparam logic [WIN_W-1:0] RIGHT_MASK  = 9'h1C0;
   localparam int unsigned      CENTRE_BIT  = 4;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // edge and control flags of one request, worked out at accept time
   typedef struct packed {
      logic emit;
      logic last;
      logic top;
      logic bottom;
      logic left;
      logic right;
   } stage_flags_type;

   // next state of the centre cell under B3/S23
   function automatic logic life_rule(input logic [WIN_W-1:0] win,
                                      input logic [WIN_W-1:0] mask);
      logic [WIN_W-1:0] hits;
      logic [3:0]       count;
      hits  = win & mask;
      count = '0;
      for (int i = 0; i < WIN_W; i++) begin
         count = count + {3'd0, hits[i]};
      end
      return (count == BIRTH_COUNT) ||
             ((count == SURVIVE_COUNT) && win[CENTRE_BIT]);
   endfunction

endpackage

### rtl/core/life_generation_stencil_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_stencil_top: streaming B3/S23 next-generation stencil
// Two line stores and a 3x3 window give each cell's next state in raster order.
// ----------------------------------------------------------------------------
// Usage
//   req_*: one cell of the current generation per request, raster order.
//   After the grid_width*grid_height cells of a frame the source sends
//   grid_width+1 padding requests whose value is ignored.
//   rsp_*: next state of the cell grid_width+1 requests back; rsp_last_of_frame
//   marks the grid's final cell, which comes out on the last padding request.
//   csr_*: grid_width (index 0) and grid_height (index 1), written while idle;
//   0 acts as 1 and values above MAX_WIDTH / MAX_HEIGHT act as the maximum.
// Timing
//   One request per cycle while rsp_ready keeps up. An accepted request is
//   registered in the read stage; the result it gives loads the output register
//   and raises rsp_valid when that stage advances. The line stores are one
//   2-bit-wide memory, read at most once and written at most once per cycle.
// Reset and stalls
//   Reset clears counters and valids; the line store is not swept, since
//   stale contents only reach cells on the grid edge, where they are masked.
//   While rsp_ready is low with a result waiting, requests that give no
//   result still pass; the first one that gives a result is held in the read
//   stage and req_ready then drops.
// ----------------------------------------------------------------------------
module life_generation_stencil_top #(
   parameter int unsigned MAX_WIDTH  = 2048,
   parameter int unsigned MAX_HEIGHT = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cell_alive,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_next_alive,
   output logic                            rsp_last_of_frame,
   // configuration port
   input  logic                            csr_we,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned WX = (WW > lgs_pkg::CSR_DATA_W) ? WW : lgs_pkg::CSR_DATA_W;
   localparam int unsigned HX = (HW > lgs_pkg::CSR_DATA_W) ? HW : lgs_pkg::CSR_DATA_W;

   typedef enum logic [1:0] {
      ROW_FIRST,
      ROW_SECOND,
      ROW_LATER
   } row_phase_type;

   logic [lgs_pkg::CSR_DATA_W-1:0] grid_width_ff;
   logic [lgs_pkg::CSR_DATA_W-1:0] grid_height_ff;

   logic [WX-1:0] width_x;
   logic [HX-1:0] height_x;

   logic [CW-1:0]   in_col_ff,  in_col_in;
   row_phase_type   in_row_ff,  in_row_in;
   logic [CW-1:0]   out_col_ff, out_col_in;
   logic [RW-1:0]   out_row_ff, out_row_in;

   logic in_last_col;
   logic out_last_col;
   logic out_last_row;

   lgs_pkg::stage_flags_type flags_in;
   lgs_pkg::stage_flags_type s1_flags_ff;

   logic          req_accept;
   logic          s1_valid_ff;
   logic          s1_adv;
   logic          s1_x_ff;
   logic [CW-1:0] s1_col_ff;
   logic [1:0]    s1_rd_ff;

   logic [1:0] line_store_ff [MAX_WIDTH];

   logic [lgs_pkg::WIN_W-1:0] window_ff, window_in;
   logic [lgs_pkg::WIN_W-1:0] mask;
   logic                      alive;

   logic rsp_valid_ff;
   logic rsp_next_alive_ff;
   logic rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= lgs_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= lgs_pkg::GRID_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lgs_pkg::REG_GRID_WIDTH:  grid_width_ff  <= csr_wdata;
            lgs_pkg::REG_GRID_HEIGHT: grid_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the grid size to 1..max
   always_comb begin
      priority if (grid_width_ff == '0)
         width_x = WX'(1);
      else if (WX'(grid_width_ff) > WX'(MAX_WIDTH))
         width_x = WX'(MAX_WIDTH);
      else
         width_x = WX'(grid_width_ff);

      priority if (grid_height_ff == '0)
         height_x = HX'(1);
      else if (HX'(grid_height_ff) > HX'(MAX_HEIGHT))
         height_x = HX'(MAX_HEIGHT);
      else
         height_x = HX'(grid_height_ff);
   end

   // handshake of the read stage
   assign s1_adv     = s1_valid_ff &&
                       (!s1_flags_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   // position tracking for the incoming request and the next result
   assign in_last_col  = (WX'(in_col_ff) + WX'(1)) >= width_x;
   assign out_last_col = (WX'(out_col_ff) + WX'(1)) >= width_x;
   assign out_last_row = (HX'(out_row_ff) + HX'(1)) >= height_x;

   always_comb begin
      flags_in.emit   = (in_row_ff == ROW_LATER) ||
                        ((in_row_ff == ROW_SECOND) && (in_col_ff != '0));
      flags_in.last   = flags_in.emit && out_last_col && out_last_row;
      flags_in.top    = (out_row_ff == '0);
      flags_in.bottom = out_last_row;
      flags_in.left   = (out_col_ff == '0);
      flags_in.right  = out_last_col;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (flags_in.last) begin
         // final cell of the frame: start over
         in_col_in  = '0;
         in_row_in  = ROW_FIRST;
         out_col_in = '0;
         out_row_in = '0;
      end else begin
         if (flags_in.emit) begin
            if (out_last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
         if (in_last_col) begin
            in_col_in = '0;
            unique case (in_row_ff)
               ROW_FIRST:  in_row_in = ROW_SECOND;
               ROW_SECOND: in_row_in = ROW_LATER;
               ROW_LATER:  in_row_in = ROW_LATER;
               default:    in_row_in = ROW_LATER;
            endcase
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= ROW_FIRST;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
         if (req_accept)
            s1_valid_ff <= 1'b1;
         else if (s1_adv)
            s1_valid_ff <= 1'b0;
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_x_ff     <= req_cell_alive;
         s1_col_ff   <= in_col_ff;
         s1_flags_ff <= flags_in;
      end
   end

   // line store: {upper, lower}, write-back of the older request bypassed
   // into a read of the same column in the same cycle
   always_ff @(posedge clock) begin
      if (s1_adv)
         line_store_ff[s1_col_ff] <= {s1_rd_ff[0], s1_x_ff};
      if (req_accept) begin
         if (s1_adv && (s1_col_ff == in_col_ff))
            s1_rd_ff <= {s1_rd_ff[0], s1_x_ff};
         else
            s1_rd_ff <= line_store_ff[in_col_ff];
      end
   end

   // window shift and neighbour count
   always_comb begin
      window_in = {s1_x_ff, s1_rd_ff[0], s1_rd_ff[1], window_ff[lgs_pkg::WIN_W-1:3]};
      mask      = lgs_pkg::NEIGH_MASK;
      if (s1_flags_ff.top)    mask = mask & ~lgs_pkg::TOP_MASK;
      if (s1_flags_ff.bottom) mask = mask & ~lgs_pkg::BOTTOM_MASK;
      if (s1_flags_ff.left)   mask = mask & ~lgs_pkg::LEFT_MASK;
      if (s1_flags_ff.right)  mask = mask & ~lgs_pkg::RIGHT_MASK;
      alive     = lgs_pkg::life_rule(window_in, mask);
   end

   always_ff @(posedge clock) begin
      if (reset)
         window_ff <= '0;
      else if (s1_adv)
         window_ff <= window_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (s1_adv && s1_flags_ff.emit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_flags_ff.emit) begin
         rsp_next_alive_ff <= alive;
         rsp_last_ff       <= s1_flags_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_alive    = rsp_next_alive_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_flags_ff.emit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_ready)
      else $error("request taken while read stage is stalled");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && flags_in.last) |=>
         (in_col_ff == '0 && out_col_ff == '0 && out_row_ff == '0 &&
          in_row_ff == ROW_FIRST))
      else $error("counters not cleared after final cell");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline not empty after reset");

   a_last_needs_emit: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags_ff.last) |-> s1_flags_ff.emit)
      else $error("final-cell flag on a request without a result");

endmodule

### dv/tb_life_generation_stencil_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_generation_stencil_top: self-checking bench for the B3/S23 stencil
// Streams raster frames of cells through the request channel and checks every
// result against an in-bench streaming model of the line stores and window.
// A short directed table comes first: a blinker on a 3x3 grid entered across
// a width change, and tiny grids with zero and small sizes. Then come the
// smallest grids and random frames, well-formed and of a wrong length, with
// random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module tb_life_generation_stencil_top;

   localparam int unsigned MAX_W          = 2048;
   localparam int unsigned MAX_H          = 2048;
   localparam int unsigned RANDOM_CELLS   = 1900;
   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned DRAIN_LIMIT    = 20000;
   localparam int unsigned PRINT_LIMIT    = 40;
   localparam int unsigned BACKPRESSURE_AT = 500;
   localparam int unsigned LONG_HOLD      = 300;
   localparam longint      TIMEOUT_NS     = 64'd30_000_000;

   // window bit groups: bits 0-2 left column, 3-5 middle, 6-8 right
   localparam logic [8:0] WIN_RING   = 9'b111_101_111;
   localparam logic [8:0] WIN_TOP    = 9'b001_001_001;
   localparam logic [8:0] WIN_BOTTOM = 9'b100_100_100;
   localparam logic [8:0] WIN_LEFT   = 9'b000_000_111;
   localparam logic [8:0] WIN_RIGHT  = 9'b111_000_000;

   typedef struct packed {
      logic next_alive;
      logic last_of_frame;
   } next_gen_type;

   typedef enum logic [1:0] {BY_PREDICTOR, NO_RESULT, TYPED} row_check_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_type;

   typedef struct packed {
      logic          load_grid;
      logic [11:0]   width;
      logic [11:0]   height;
      logic          cell_state;
      row_check_type check;
      logic          next_alive;
      logic          last_of_frame;
   } stim_row_type;

   // directed rows: 3x3 blinker whose first cell goes in at the reset size,
   // a zero-sized grid (acts as 1x1) and a full 2x1 row
   localparam stim_row_type DIRECTED_ROWS [21] = '{
      '{1'b0, 12'd0, 12'd0, 1'b0, NO_RESULT,    1'b0, 1'b0},
      '{1'b1, 12'd3, 12'd3, 1'b0, NO_RESULT,    1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, NO_RESULT,    1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, NO_RESULT,    1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b1, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, TYPED,        1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, TYPED,        1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, TYPED,        1'b1, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, TYPED,        1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b1, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b0, 1'b1},
      '{1'b1, 12'd0, 12'd0, 1'b1, NO_RESULT,    1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, NO_RESULT,    1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, TYPED,        1'b0, 1'b1},
      '{1'b1, 12'd2, 12'd1, 1'b1, BY_PREDICTOR, 1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, BY_PREDICTOR, 1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, BY_PREDICTOR, 1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b1, BY_PREDICTOR, 1'b0, 1'b0},
      '{1'b0, 12'd0, 12'd0, 1'b0, BY_PREDICTOR, 1'b0, 1'b0}
   };

   // smallest grids: single cell, one row, one column
   localparam logic [11:0] EDGE_W [4] = '{12'd1, 12'd2, 12'd1, 12'd3};
   localparam logic [11:0] EDGE_H [4] = '{12'd1, 12'd1, 12'd2, 12'd1};

   localparam int unsigned FILL_PERCENT [5] = '{5, 25, 50, 75, 95};

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_cell_alive;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_next_alive;
   logic                           rsp_last_of_frame;
   logic                           csr_we;
   logic [lgs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lgs_pkg::CSR_DATA_W-1:0] csr_wdata;

   // model state of the stencil
   logic        row_above_mem [0:MAX_W-1];
   logic        row_prev_mem  [0:MAX_W-1];
   logic [8:0]  stencil_win;
   logic [10:0] feed_col;
   logic [11:0] feed_row;
   logic [10:0] emit_col;
   logic [10:0] emit_row;
   logic [11:0] grid_width_q;
   logic [11:0] grid_height_q;

   next_gen_type  next_gen_q [$];
   next_gen_type  got_gen;
   int unsigned   mismatch_count = 0;
   int unsigned   results_seen   = 0;
   int unsigned   cells_fed      = 0;
   idle_mode_type req_idle       = IDLE_FULL;
   idle_mode_type rsp_idle       = IDLE_SPARSE;

   life_generation_stencil_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cell_alive    (req_cell_alive),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_next_alive    (rsp_next_alive),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // zero acts as one, anything past the given maximum acts as that maximum
   function automatic logic [11:0] usable_dim(input logic [11:0] v, input int unsigned hi);
      if (v == 12'd0) return 12'd1;
      if (v > hi) return 12'(hi);
      return v;
   endfunction

   function automatic int unsigned draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(3) == 0) ? $urandom_range(9) : 0;
         default:     return $urandom_range(9);
      endcase
   endfunction

   function automatic logic [11:0] pick_dim(input int unsigned usual_hi,
                                            input int unsigned wide_hi);
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return 12'd0;
      if (roll == 1) return 12'($urandom_range(wide_hi, usual_hi + 1));
      return 12'($urandom_range(usual_hi, 1));
   endfunction

   function automatic logic at_frame_start();
      return (feed_col == 11'd0) && (feed_row == 12'd0);
   endfunction

   // one stream step: shift the line stores and window, then score the cell
   // that sits grid_width+1 positions back once it has all its neighbours
   function automatic void step_life_stencil(input logic cell_state, output logic emitted,
                                             output next_gen_type predicted);
      logic [11:0] w;
      logic [11:0] h;
      logic        above;
      logic        prev;
      logic [8:0]  ring;
      logic [3:0]  live;
      logic        col_last;
      logic        row_last;
      w = usable_dim(grid_width_q, MAX_W);
      h = usable_dim(grid_height_q, MAX_H);
      above = row_above_mem[feed_col];
      prev  = row_prev_mem[feed_col];
      row_above_mem[feed_col] = prev;
      row_prev_mem[feed_col]  = cell_state;
      stencil_win = {cell_state, prev, above, stencil_win[8:3]};

      emitted   = (feed_row >= 12'd2) || (feed_row == 12'd1 && feed_col != 11'd0);
      predicted = '0;
      if (emitted) begin
         col_last = {1'b0, emit_col} >= w - 12'd1;
         row_last = {1'b0, emit_row} >= h - 12'd1;
         // neighbours off the grid count as dead
         ring = WIN_RING;
         if (emit_row == 11'd0) ring = ring & ~WIN_TOP;
         if (row_last) ring = ring & ~WIN_BOTTOM;
         if (emit_col == 11'd0) ring = ring & ~WIN_LEFT;
         if (col_last) ring = ring & ~WIN_RIGHT;
         live = 4'($countones(stencil_win & ring));
         predicted.next_alive    = (live == 4'd3) || (live == 4'd2 && stencil_win[4]);
         predicted.last_of_frame = col_last && row_last;
         if (col_last && row_last) begin
            feed_col = '0;
            feed_row = '0;
            emit_col = '0;
            emit_row = '0;
            return;
         end
         if (col_last) begin
            emit_col = '0;
            emit_row = emit_row + 11'd1;
         end else begin
            emit_col = emit_col + 11'd1;
         end
      end

      if ({1'b0, feed_col} >= w - 12'd1) begin
         feed_col = '0;
         if (feed_row != 12'hFFF) feed_row = feed_row + 12'd1;
      end else begin
         feed_col = feed_col + 11'd1;
      end
   endfunction

   // offer one cell and step the model at the edge that takes it
   task automatic feed_cell(input logic cell_state, output logic emitted,
                            output next_gen_type predicted);
      int unsigned gap;
      gap = draw_wait(req_idle);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_alive <= cell_state;
      do @(posedge clock); while (!req_ready);
      step_life_stencil(cell_state, emitted, predicted);
      cells_fed++;
   endtask

   task automatic feed_predicted(input logic cell_state);
      logic         emitted;
      next_gen_type predicted;
      feed_cell(cell_state, emitted, predicted);
      if (emitted) next_gen_q.push_back(predicted);
   endtask

   // size registers change only with nothing in flight
   task automatic program_grid(input logic [11:0] width, input logic [11:0] height);
      req_valid <= 1'b0;
      while (next_gen_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= lgs_pkg::REG_GRID_WIDTH;
      csr_wdata <= width;
      @(posedge clock);
      csr_index <= lgs_pkg::REG_GRID_HEIGHT;
      csr_wdata <= height;
      @(posedge clock);
      csr_we        <= 1'b0;
      grid_width_q  = width;
      grid_height_q = height;
   endtask

   // one frame of random cells; a broken frame has the wrong cell count,
   // and padding runs until the model has scored the final cell
   task automatic run_frame(input logic reprogram, input logic [11:0] width,
                            input logic [11:0] height, input int unsigned fill,
                            input logic broken);
      int unsigned area;
      int unsigned count;
      if (reprogram) program_grid(width, height);
      area  = usable_dim(grid_width_q, MAX_W) * usable_dim(grid_height_q, MAX_H);
      count = broken ? $urandom_range(2 * area + 3, 1) : area;
      repeat (count) feed_predicted($urandom_range(99) < fill);
      do feed_predicted(1'($urandom_range(1))); while (!at_frame_start());
   endtask

   // result side: random stalls per result, one long hold partway in
   initial begin : result_sink
      int unsigned hold_cycles;
      int unsigned taken;
      hold_cycles = 0;
      taken       = 0;
      rsp_ready   = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
            hold_cycles = (taken == BACKPRESSURE_AT) ? LONG_HOLD : draw_wait(rsp_idle);
         end
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (next_gen_q.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with none expected", results_seen));
         end else begin
            got_gen = next_gen_q.pop_front();
            if (rsp_next_alive !== got_gen.next_alive) begin
               flag_mismatch($sformatf("result %0d next_alive %b, expected %b",
                                       results_seen, rsp_next_alive, got_gen.next_alive));
            end
            if (rsp_last_of_frame !== got_gen.last_of_frame) begin
               flag_mismatch($sformatf("result %0d last_of_frame %b, expected %b",
                                       results_seen, rsp_last_of_frame,
                                       got_gen.last_of_frame));
            end
         end
         results_seen++;
      end
   end

   initial begin : stimulus
      int unsigned  row;
      int unsigned  start_cells;
      int unsigned  spin;
      logic         emitted;
      next_gen_type predicted;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cell_alive = 1'b0;
      csr_we         = 1'b0;
      csr_index      = lgs_pkg::REG_GRID_WIDTH;
      csr_wdata      = '0;

      for (int i = 0; i < MAX_W; i++) begin
         row_above_mem[i] = 1'b0;
         row_prev_mem[i]  = 1'b0;
      end
      stencil_win   = '0;
      feed_col      = '0;
      feed_row      = '0;
      emit_col      = '0;
      emit_row      = '0;
      grid_width_q  = lgs_pkg::GRID_WIDTH_RESET;
      grid_height_q = lgs_pkg::GRID_HEIGHT_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (row = 0; row < $size(DIRECTED_ROWS); row++) begin
         if (DIRECTED_ROWS[row].load_grid) begin
            program_grid(DIRECTED_ROWS[row].width, DIRECTED_ROWS[row].height);
         end
         feed_cell(DIRECTED_ROWS[row].cell_state, emitted, predicted);
         case (DIRECTED_ROWS[row].check)
            BY_PREDICTOR: if (emitted) next_gen_q.push_back(predicted);
            TYPED: next_gen_q.push_back(next_gen_type'{DIRECTED_ROWS[row].next_alive,
                                                       DIRECTED_ROWS[row].last_of_frame});
            default: ;
         endcase
      end

      // smallest grids, sender back to back
      req_idle = IDLE_NONE;
      for (row = 0; row < $size(EDGE_W); row++) begin
         rsp_idle = idle_mode_type'($urandom_range(2));
         run_frame(1'b1, EDGE_W[row], EDGE_H[row], 50, 1'b0);
      end

      // random frames, mostly well-formed
      start_cells = cells_fed;
      while (cells_fed - start_cells < RANDOM_CELLS) begin
         req_idle = idle_mode_type'($urandom_range(2));
         rsp_idle = idle_mode_type'($urandom_range(2));
         run_frame((cells_fed == start_cells) || ($urandom_range(3) != 0),
                   pick_dim(10, 40), pick_dim(8, 24),
                   FILL_PERCENT[$urandom_range(4)], $urandom_range(4) == 0);
      end

      req_valid <= 1'b0;
      spin = 0;
      while (next_gen_q.size() != 0 && spin < DRAIN_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (next_gen_q.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", next_gen_q.size()));
      end

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### life_generation_stencil_top.f
rtl/core/lgs_pkg.sv
rtl/core/life_generation_stencil_top.sv
dv/tb_life_generation_stencil_top.sv
